/* rtl/i2a_pkg.sv */
// ============================================================================
// i2a_pkg: shared types and constants of the integer to ASCII formatter
// Character codes, radix codes and the command and status groups that pass
// between the controller and the datapath.
// ============================================================================
`default_nettype none

package i2a_pkg;

    // Number of BCD digits held by the datapath (enough for 2^64 - 1).
    localparam int unsigned MAX_DIGITS = 20;
    // Number of hex digits in a 64-bit magnitude.
    localparam int unsigned HEX_DIGITS = 16;
    localparam int unsigned MAG_W      = 64;
    localparam int unsigned DIG_W      = 4 * MAX_DIGITS;
    localparam int unsigned CNT_W      = 5;
    localparam int unsigned FW_W       = 6;

    // Radix selector codes.
    localparam logic [1:0] RADIX_DEC   = 2'd0;
    localparam logic [1:0] RADIX_HEX_L = 2'd1;

    // ASCII codes.
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_MINUS   = 8'h2D;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic conv_step;
        logic trim_step;
        logic prep;
        logic emit_sign;
        logic emit_pad;
        logic emit_digit;
    } i2a_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hex_mode;
        logic top_zero;
        logic nd_one;
        logic pad_zero;
        logic sign_needed;
    } i2a_stat_t;

endpackage : i2a_pkg

`default_nettype wire

/* rtl/i2a_ctrl.sv */
// ============================================================================
// i2a_ctrl: sequencing controller of the integer to ASCII formatter
// Steps through input capture, binary to BCD conversion, leading zero
// trimming, pad count preparation and character emission.
// ============================================================================
`default_nettype none

module i2a_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic              m_tready,
    output logic                   m_tvalid,
    output i2a_pkg::i2a_cmd_t      cmd,
    input  wire i2a_pkg::i2a_stat_t stat
);
    import i2a_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CONV  = 3'd1;
    localparam logic [2:0] ST_TRIM  = 3'd2;
    localparam logic [2:0] ST_SIGN  = 3'd3;
    localparam logic [2:0] ST_PAD   = 3'd4;
    localparam logic [2:0] ST_DIGIT = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [5:0] step_reg, step_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic       out_free;
    logic       emit;

    // The output register can take a character when empty or being drained.
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign emit     = cmd.emit_sign || cmd.emit_pad || cmd.emit_digit;

    // Next state and command decode.
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    step_next  = '0;
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                if (stat.hex_mode) begin
                    state_next = ST_TRIM;
                end else begin
                    cmd.conv_step = 1'b1;
                    step_next     = step_reg + 6'd1;
                    if (step_reg == 6'h3F) begin
                        state_next = ST_TRIM;
                    end
                end
            end
            ST_TRIM: begin
                if (stat.top_zero && !stat.nd_one) begin
                    cmd.trim_step = 1'b1;
                end else begin
                    cmd.prep   = 1'b1;
                    state_next = ST_SIGN;
                end
            end
            ST_SIGN: begin
                if (!stat.sign_needed) begin
                    state_next = ST_PAD;
                end else if (out_free) begin
                    cmd.emit_sign = 1'b1;
                    state_next    = ST_PAD;
                end
            end
            ST_PAD: begin
                if (stat.pad_zero) begin
                    state_next = ST_DIGIT;
                end else if (out_free) begin
                    cmd.emit_pad = 1'b1;
                end
            end
            ST_DIGIT: begin
                if (out_free) begin
                    cmd.emit_digit = 1'b1;
                    if (stat.nd_one) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid: set by any emitted character, cleared by a transfer.
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (emit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            step_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule : i2a_ctrl

`default_nettype wire

/* rtl/i2a_dp.sv */
// ============================================================================
// i2a_dp: datapath of the integer to ASCII formatter
// Holds the operand, the shift-and-add-3 BCD converter, the digit and pad
// counters and the output character register.
// ============================================================================
`default_nettype none

module i2a_dp #(
    parameter int unsigned WIDTH_LIMIT = 40
) (
    input  wire logic                 aclk,
    input  wire logic [63:0]          in_magnitude,
    input  wire logic                 in_negative,
    input  wire logic [1:0]           in_radix_mode,
    input  wire logic                 in_zero_pad,
    input  wire logic [5:0]           in_field_width,
    input  wire i2a_pkg::i2a_cmd_t    cmd,
    output i2a_pkg::i2a_stat_t        stat,
    output logic [7:0]                out_char,
    output logic                      out_last
);
    import i2a_pkg::*;

    localparam logic [FW_W-1:0] WidthMax = FW_W'(WIDTH_LIMIT);

    logic [MAG_W-1:0] bin_reg, bin_next;
    logic [DIG_W-1:0] dig_reg, dig_next;
    logic [DIG_W-1:0] dig_adj;
    logic [CNT_W-1:0] nd_reg, nd_next;
    logic [FW_W-1:0]  pad_reg, pad_next;
    logic [FW_W-1:0]  width_reg, width_next;
    logic [1:0]       mode_reg, mode_next;
    logic             neg_reg, neg_next;
    logic             zpad_reg, zpad_next;
    logic [7:0]       char_reg, char_next;
    logic             last_reg, last_next;
    logic [3:0]       top_nib;
    logic [7:0]       digit_char;
    logic [FW_W-1:0]  nd_wide;

    assign top_nib = dig_reg[DIG_W-1 -: 4];
    assign nd_wide = FW_W'(nd_reg);

    // Add 3 to every BCD digit of five or more before the next shift.
    always_comb begin
        logic [3:0] d;
        for (int i = 0; i < int'(MAX_DIGITS); i++) begin
            d = dig_reg[4*i +: 4];
            dig_adj[4*i +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
        end
    end

    // Character for the leading digit.
    always_comb begin
        if (top_nib < 4'd10) begin
            digit_char = CHAR_ZERO + {4'd0, top_nib};
        end else if (mode_reg == RADIX_HEX_L) begin
            digit_char = CHAR_LOWER_A + {4'd0, top_nib - 4'd10};
        end else begin
            digit_char = CHAR_UPPER_A + {4'd0, top_nib - 4'd10};
        end
    end

    // Status to the controller.
    always_comb begin
        stat.hex_mode    = (mode_reg != RADIX_DEC);
        stat.top_zero    = (top_nib == 4'd0);
        stat.nd_one      = (nd_reg == CNT_W'(1));
        stat.pad_zero    = (pad_reg == '0);
        stat.sign_needed = (mode_reg == RADIX_DEC) && neg_reg;
    end

    // Register updates under controller command.
    always_comb begin
        bin_next   = bin_reg;
        dig_next   = dig_reg;
        nd_next    = nd_reg;
        pad_next   = pad_reg;
        width_next = width_reg;
        mode_next  = mode_reg;
        neg_next   = neg_reg;
        zpad_next  = zpad_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        if (cmd.load) begin
            mode_next  = in_radix_mode;
            neg_next   = in_negative;
            zpad_next  = in_zero_pad;
            width_next = (in_field_width > WidthMax) ? WidthMax : in_field_width;
            bin_next   = in_magnitude;
            if (in_radix_mode == RADIX_DEC) begin
                dig_next = '0;
                nd_next  = CNT_W'(MAX_DIGITS);
            end else begin
                dig_next = {in_magnitude, {(DIG_W - MAG_W){1'b0}}};
                nd_next  = CNT_W'(HEX_DIGITS);
            end
        end
        if (cmd.conv_step) begin
            dig_next = {dig_adj[DIG_W-2:0], bin_reg[MAG_W-1]};
            bin_next = {bin_reg[MAG_W-2:0], 1'b0};
        end
        if (cmd.trim_step) begin
            dig_next = {dig_reg[DIG_W-5:0], 4'd0};
            nd_next  = nd_reg - CNT_W'(1);
        end
        if (cmd.prep) begin
            pad_next = (width_reg > nd_wide) ? width_reg - nd_wide : '0;
        end
        if (cmd.emit_sign) begin
            char_next = CHAR_MINUS;
            last_next = 1'b0;
        end
        if (cmd.emit_pad) begin
            char_next = zpad_reg ? CHAR_ZERO : CHAR_SPACE;
            last_next = 1'b0;
            pad_next  = pad_reg - FW_W'(1);
        end
        if (cmd.emit_digit) begin
            char_next = digit_char;
            last_next = (nd_reg == CNT_W'(1));
            dig_next  = {dig_reg[DIG_W-5:0], 4'd0};
            nd_next   = nd_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        bin_reg   <= bin_next;
        dig_reg   <= dig_next;
        nd_reg    <= nd_next;
        pad_reg   <= pad_next;
        width_reg <= width_next;
        mode_reg  <= mode_next;
        neg_reg   <= neg_next;
        zpad_reg  <= zpad_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
    end

    assign out_char = char_reg;
    assign out_last = last_reg;

endmodule : i2a_dp

`default_nettype wire

/* rtl/integer_to_ascii_formatter.sv */
// ============================================================================
// integer_to_ascii_formatter: 64-bit integer to padded ASCII text
// Formats a magnitude as decimal or hex characters with optional sign and
// space or zero padding, one character per output transfer.
// ============================================================================
//
//  Channel  Direction  tdata                               tuser / tlast
//  s_       in         [63:0] magnitude, [69:64] width     tuser [0] neg, [2:1] radix, [3] zpad
//  m_       out        [7:0] out_char                      tlast = last_char
//
//  Decimal items: a load, 64 shift-and-add-3 steps, trimming of up to 19
//  leading zero digits, the pad count, a sign slot (carrying the minus when
//  printed), leaving the pad phase, then one cycle per pad or digit character
//  while the output is free. Hex items pass the converter state without shifting and trim at most 15 digits.
//  Reset (aresetn low, synchronous) idles the controller and empties the
//  output register. A low m_tready holds the emission; the next input is
//  taken once the last character sits in the output register.
// ============================================================================
`default_nettype none

module integer_to_ascii_formatter #(
    parameter int unsigned WIDTH_LIMIT = 40
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,   // magnitude[63:0], field_width[69:64], [71:70] unused
    input  wire logic [3:0]  s_tuser,   // negative, radix_mode[1:0], zero_pad
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // out_char[7:0]
    output logic             m_tlast
);
    import i2a_pkg::*;

    i2a_cmd_t  cmd;
    i2a_stat_t stat;

    // Sequencing controller.
    i2a_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .cmd      (cmd),
        .stat     (stat)
    );

    // Conversion and output datapath.
    i2a_dp #(
        .WIDTH_LIMIT (WIDTH_LIMIT)
    ) u_dp (
        .aclk           (aclk),
        .in_magnitude   (s_tdata[63:0]),
        .in_negative    (s_tuser[0]),
        .in_radix_mode  (s_tuser[2:1]),
        .in_zero_pad    (s_tuser[3]),
        .in_field_width (s_tdata[69:64]),
        .cmd            (cmd),
        .stat           (stat),
        .out_char       (m_tdata),
        .out_last       (m_tlast)
    );

endmodule : integer_to_ascii_formatter

`default_nettype wire
